/* hw/rtl/rgbdith_pkg.sv */
// ----------------------------------------------------------------------------
// rgbdith_pkg
// Shared constants for the RGB565 to 1 bpp error diffusion ditherer:
// parameter defaults, register indexes, reset values and quantiser levels.
// ----------------------------------------------------------------------------
package rgbdith_pkg;

  // Parameter defaults
  localparam int MAX_WIDTH_DEF  = 1024;
  localparam int ERROR_BITS_DEF = 16;

  // Working width of the per-pixel arithmetic (holds error sums times nine)
  localparam int WORK_BITS = 32;

  // Configuration port
  localparam int CFG_DATA_BITS  = 16;
  localparam int CFG_INDEX_BITS = 1;
  localparam logic [CFG_INDEX_BITS-1:0] CFG_IMAGE_WIDTH  = 1'b0;
  localparam logic [CFG_INDEX_BITS-1:0] CFG_IMAGE_HEIGHT = 1'b1;

  localparam int WIDTH_BITS  = 11;
  localparam int HEIGHT_BITS = 16;
  localparam logic [WIDTH_BITS-1:0]  WIDTH_RESET  = 11'd320;
  localparam logic [HEIGHT_BITS-1:0] HEIGHT_RESET = 16'd240;

  // Payload widths
  localparam int PIXEL_BITS = 16;
  localparam int WORD_BITS  = 32;
  localparam int COUNT_BITS = 6;
  localparam int POS_BITS   = 5;

  // White levels per channel and the luminance threshold
  localparam logic [7:0] FULL_RED   = 8'hf8;
  localparam logic [7:0] FULL_GREEN = 8'hfc;
  localparam logic [7:0] FULL_BLUE  = 8'hf8;
  localparam logic [7:0] LUM_THRESH = 8'h80;

endpackage

/* hw/rtl/rgb565_error_diffusion_mono_dither.sv */
// ----------------------------------------------------------------------------
// rgb565_error_diffusion_mono_dither
// Floyd-Steinberg dither of a raster RGB565 stream to packed 1 bpp words.
// ----------------------------------------------------------------------------
// The block takes one pixel per clock unless a pending word holds stage B,
// and has two stages: accepting an item reads its column of the down-error
// line memory; stage B then applies the diffused error, decides black or
// white, writes the error back and packs the bit. A packed word is loaded
// into the output register when stage B retires the pixel completing it;
// the input keeps flowing while that word waits, and stalls only when a
// second word is due before the first is taken. The line memory holds one
// 3 x ERROR_BITS entry per column and needs no clearing after reset: the
// first row of every frame reads zero error, and a fill mark makes columns
// not yet written since reset read as zero. It is written at most once per
// pixel through one port; the row-end extra write is held in a one-entry
// buffer, retired on the next free cycle and forwarded onto the read path.
module rgb565_error_diffusion_mono_dither #(
  parameter int MAX_WIDTH  = rgbdith_pkg::MAX_WIDTH_DEF,
  parameter int ERROR_BITS = rgbdith_pkg::ERROR_BITS_DEF
) (
  input  logic                                    clk,
  input  logic                                    rst_n,
  // Configuration writes
  input  logic                                    cfg_wr_en,
  input  logic [rgbdith_pkg::CFG_INDEX_BITS-1:0]  cfg_index,
  input  logic [rgbdith_pkg::CFG_DATA_BITS-1:0]   cfg_wdata,
  // Pixel input
  input  logic                                    in_valid,
  output logic                                    in_ready,
  input  logic [rgbdith_pkg::PIXEL_BITS-1:0]      in_pixel_rgb565,
  // Packed output
  output logic                                    out_valid,
  input  logic                                    out_ready,
  output logic [rgbdith_pkg::WORD_BITS-1:0]       out_packed_bits,
  output logic [rgbdith_pkg::COUNT_BITS-1:0]      out_bit_count,
  output logic                                    out_last_of_frame
);

  import rgbdith_pkg::*;

  localparam int EB    = ERROR_BITS;
  localparam int WW    = WORK_BITS;
  localparam int XW    = $clog2(MAX_WIDTH);
  localparam int CW    = (XW + 1 > WIDTH_BITS) ? XW + 1 : WIDTH_BITS;
  localparam int ENT_W = 3 * EB;

  localparam logic signed [WW-1:0] EMAX = (WW'(1) <<< (EB - 1)) - WW'(1);
  localparam logic signed [WW-1:0] EMIN = -EMAX - WW'(1);

  // Clamp a working value to a signed error of EB bits
  function automatic logic signed [EB-1:0] sat_err(input logic signed [WW-1:0] v);
    logic signed [WW-1:0] r;
    r = v;
    if (v > EMAX) begin
      r = EMAX;
    end else if (v < EMIN) begin
      r = EMIN;
    end
    return r[EB-1:0];
  endfunction

  // --------------------------------------------------------------------------
  // Configuration registers
  // --------------------------------------------------------------------------
  logic [WIDTH_BITS-1:0]  image_width_r;
  logic [HEIGHT_BITS-1:0] image_height_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      image_width_r  <= WIDTH_RESET;
      image_height_r <= HEIGHT_RESET;
    end else if (cfg_wr_en) begin
      unique case (cfg_index)
        CFG_IMAGE_WIDTH:  image_width_r  <= cfg_wdata[WIDTH_BITS-1:0];
        CFG_IMAGE_HEIGHT: image_height_r <= cfg_wdata[HEIGHT_BITS-1:0];
        default: ;
      endcase
    end
  end

  // --------------------------------------------------------------------------
  // Stage A: raster position, row and frame ends, line memory read
  // --------------------------------------------------------------------------
  logic [XW-1:0]          col_r;
  logic [HEIGHT_BITS-1:0] row_r;
  logic [CW-1:0]          w_eff;
  logic [HEIGHT_BITS-1:0] h_eff;
  logic                   a_row_end;
  logic                   a_frame_end;
  logic                   in_fire;

  // Stage B control
  logic                   b_valid_r;
  logic                   b_fire;
  logic                   b_emit;

  always_comb begin
    w_eff = CW'(image_width_r);
    if (w_eff == '0) begin
      w_eff = CW'(1);
    end else if (w_eff > CW'(MAX_WIDTH)) begin
      w_eff = CW'(MAX_WIDTH);
    end
    h_eff = (image_height_r == '0) ? HEIGHT_BITS'(1) : image_height_r;
    a_row_end   = (CW'(col_r) + CW'(1)) >= w_eff;
    a_frame_end = a_row_end &&
                  (({1'b0, row_r} + (HEIGHT_BITS+1)'(1)) >= {1'b0, h_eff});
  end

  assign in_ready = !b_valid_r || b_fire;
  assign in_fire  = in_valid && in_ready;

  // Advance the raster counters on each accepted item
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col_r <= '0;
      row_r <= '0;
    end else if (in_fire) begin
      if (a_row_end) begin
        col_r <= '0;
        row_r <= a_frame_end ? '0 : row_r + HEIGHT_BITS'(1);
      end else begin
        col_r <= col_r + XW'(1);
      end
    end
  end

  // --------------------------------------------------------------------------
  // Line memory write port and row-end buffer
  // --------------------------------------------------------------------------
  logic [ENT_W-1:0] line_mem [MAX_WIDTH];
  logic [ENT_W-1:0] mem_q;
  logic [XW:0]      fill_r;

  logic             buf_valid_r;
  logic [XW-1:0]    buf_addr_r;
  logic [ENT_W-1:0] buf_data_r;
  logic             buf_valid_nxt;
  logic             buf_set;
  logic             buf_flush;

  logic             w1_en;
  logic [ENT_W-1:0] w1_data;
  logic [ENT_W-1:0] p0_data;
  logic             wr_en;
  logic [XW-1:0]    wr_addr;
  logic [ENT_W-1:0] wr_data;
  logic [ENT_W-1:0] lastwr_data_r;

  // Stage B payload
  logic [XW-1:0]         b_x_r;
  logic                  b_row_end_r;
  logic                  b_frame_end_r;
  logic                  b_first_row_r;
  logic                  b_unfilled_r;
  logic                  b_sel_buf_r;
  logic                  b_sel_wr_r;
  logic [PIXEL_BITS-1:0] b_pixel_r;

  assign buf_set   = b_fire && b_row_end_r;
  assign buf_flush = buf_valid_r && !w1_en && (!b_valid_r || b_fire);
  assign wr_en     = w1_en || buf_flush;
  assign wr_addr   = w1_en ? (b_x_r - XW'(1)) : buf_addr_r;
  assign wr_data   = w1_en ? w1_data : buf_data_r;

  always_comb begin
    buf_valid_nxt = buf_valid_r;
    if (buf_flush) begin
      buf_valid_nxt = 1'b0;
    end
    if (buf_set) begin
      buf_valid_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      buf_valid_r <= 1'b0;
    end else begin
      buf_valid_r <= buf_valid_nxt;
    end
  end

  // Hold the row-end entry until the port is free
  always_ff @(posedge clk) begin
    if (buf_set) begin
      buf_addr_r <= b_x_r;
      buf_data_r <= p0_data;
    end
  end

  // Track how far the line has been written since reset; columns fill in order
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fill_r <= '0;
    end else if (wr_en && ({1'b0, wr_addr} >= fill_r)) begin
      fill_r <= {1'b0, wr_addr} + (XW+1)'(1);
    end
  end

  // Memory: one write, one registered read per cycle
  always_ff @(posedge clk) begin
    if (wr_en) begin
      line_mem[wr_addr] <= wr_data;
      lastwr_data_r     <= wr_data;
    end
    if (in_fire) begin
      mem_q <= line_mem[col_r];
    end
  end

  // --------------------------------------------------------------------------
  // Stage B register
  // --------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      b_valid_r <= 1'b0;
    end else if (in_fire) begin
      b_valid_r <= 1'b1;
    end else if (b_fire) begin
      b_valid_r <= 1'b0;
    end
  end

  // Capture the item and where its down error really lives this cycle
  always_ff @(posedge clk) begin
    if (in_fire) begin
      b_pixel_r     <= in_pixel_rgb565;
      b_x_r         <= col_r;
      b_row_end_r   <= a_row_end;
      b_frame_end_r <= a_frame_end;
      b_first_row_r <= (row_r == '0);
      b_unfilled_r  <= ({1'b0, col_r} >= fill_r);
      b_sel_buf_r   <= buf_valid_nxt && (buf_set ? b_x_r : buf_addr_r) == col_r;
      b_sel_wr_r    <= wr_en && (wr_addr == col_r);
    end
  end

  // --------------------------------------------------------------------------
  // Stage B: apply error, threshold, diffuse
  // --------------------------------------------------------------------------
  logic signed [EB-1:0] right_r [3];
  logic signed [EB-1:0] pend0_r [3];
  logic signed [EB-1:0] pend1_r [3];

  logic signed [EB-1:0] right_nxt [3];
  logic signed [EB-1:0] p0_nxt    [3];
  logic signed [EB-1:0] p1_nxt    [3];
  logic signed [EB-1:0] w1_err    [3];

  logic [ENT_W-1:0]      down_raw;
  logic signed [WW-1:0]  chan   [3];
  logic signed [WW-1:0]  diff   [3];
  logic [7:0]            base   [3];
  logic [7:0]            full   [3];
  logic signed [WW-1:0]  lum;
  logic                  white;

  always_comb begin
    if (b_sel_buf_r) begin
      down_raw = buf_data_r;
    end else if (b_sel_wr_r) begin
      down_raw = lastwr_data_r;
    end else if (b_unfilled_r) begin
      down_raw = '0;
    end else begin
      down_raw = mem_q;
    end
    base[0] = {b_pixel_r[15:11], 3'b000};
    base[1] = {b_pixel_r[10:5],  2'b00};
    base[2] = {b_pixel_r[4:0],   3'b000};
    full[0] = FULL_RED;
    full[1] = FULL_GREEN;
    full[2] = FULL_BLUE;
    lum = '0;
    for (int c = 0; c < 3; c++) begin
      chan[c] = WW'(signed'({1'b0, base[c]})) + WW'(right_r[c]);
      if (!b_first_row_r) begin
        chan[c] = chan[c] + WW'(signed'(down_raw[(2-c)*EB +: EB]));
      end
    end
    // Shift-based luminance; negative channels count as zero
    if (chan[0] > 0) lum = lum + ((chan[0] * 5) >>> 4);
    if (chan[1] > 0) lum = lum + ((chan[1] * 9) >>> 4);
    if (chan[2] > 0) lum = lum + (chan[2] >>> 3);
    white = lum > WW'(signed'({1'b0, LUM_THRESH}));
    for (int c = 0; c < 3; c++) begin
      diff[c] = chan[c] - (white ? WW'(signed'({1'b0, full[c]})) : WW'(0));
      right_nxt[c] = sat_err((diff[c] * 7) >>> 4);
      w1_err[c]    = sat_err(WW'(pend0_r[c]) + ((diff[c] * 3) >>> 4));
      p0_nxt[c]    = sat_err(WW'(pend1_r[c]) + ((diff[c] * 5) >>> 4));
      p1_nxt[c]    = sat_err(diff[c] >>> 4);
    end
    w1_data = {w1_err[0], w1_err[1], w1_err[2]};
    p0_data = {p0_nxt[0], p0_nxt[1], p0_nxt[2]};
  end

  assign w1_en = b_fire && (b_x_r != '0);

  // Carry the row errors; drop them at the row end
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int c = 0; c < 3; c++) begin
        right_r[c] <= '0;
        pend0_r[c] <= '0;
        pend1_r[c] <= '0;
      end
    end else if (b_fire) begin
      for (int c = 0; c < 3; c++) begin
        right_r[c] <= b_row_end_r ? '0 : right_nxt[c];
        pend0_r[c] <= b_row_end_r ? '0 : p0_nxt[c];
        pend1_r[c] <= b_row_end_r ? '0 : p1_nxt[c];
      end
    end
  end

  // --------------------------------------------------------------------------
  // Bit packing and output register
  // --------------------------------------------------------------------------
  logic [WORD_BITS-1:0] pack_word_r;
  logic [POS_BITS-1:0]  pack_pos_r;
  logic [WORD_BITS-1:0] pack_word_nxt;
  logic                 out_valid_r;
  logic [WORD_BITS-1:0] out_word_r;
  logic [COUNT_BITS-1:0] out_count_r;
  logic                 out_last_r;

  assign b_emit = (pack_pos_r == {POS_BITS{1'b1}}) || b_frame_end_r;
  assign b_fire = b_valid_r && (!b_emit || !out_valid_r || out_ready);

  always_comb begin
    pack_word_nxt = pack_word_r;
    pack_word_nxt[pack_pos_r] = pack_word_r[pack_pos_r] | white;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pack_word_r <= '0;
      pack_pos_r  <= '0;
      out_valid_r <= 1'b0;
    end else begin
      // Raise valid on a new word, drop it once the held word is taken
      if (b_fire && b_emit) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
      if (b_fire) begin
        if (b_emit) begin
          pack_word_r <= '0;
          pack_pos_r  <= '0;
        end else begin
          pack_word_r <= pack_word_nxt;
          pack_pos_r  <= pack_pos_r + POS_BITS'(1);
        end
      end
    end
  end

  // Load the finished word
  always_ff @(posedge clk) begin
    if (b_fire && b_emit) begin
      out_word_r  <= pack_word_nxt;
      out_count_r <= COUNT_BITS'(pack_pos_r) + COUNT_BITS'(1);
      out_last_r  <= b_frame_end_r;
    end
  end

  assign out_valid         = out_valid_r;
  assign out_packed_bits   = out_word_r;
  assign out_bit_count     = out_count_r;
  assign out_last_of_frame = out_last_r;

endmodule

/* tb/rgb565_error_diffusion_mono_dither_tb.sv */
// ----------------------------------------------------------------------------
// rgb565_error_diffusion_mono_dither_tb
// Self-checking bench for the RGB565 to 1 bpp error diffusion ditherer.
// A behavioural model tracks the per-channel error line, the right and
// pending down errors and the bit packing; every packed word leaving the
// block is compared field by field with the predicted word. Pixels arrive
// with random gaps and words are taken under random back-pressure.
// ----------------------------------------------------------------------------
module rgb565_error_diffusion_mono_dither_tb;
  import rgbdith_pkg::*;

  localparam int     LINE_COLS    = MAX_WIDTH_DEF;
  localparam int     ERR_BITS     = ERROR_BITS_DEF;
  localparam longint ERR_HI       = (longint'(1) << (ERR_BITS - 1)) - 1;
  localparam longint ERR_LO       = -ERR_HI - 1;
  localparam int     RANDOM_ITEMS = 600;
  localparam int     FLUSH_CYCLES = 8;
  localparam int     DRAIN_LIMIT  = 5000;

  typedef struct packed {
    logic [WORD_BITS-1:0]  bits;
    logic [COUNT_BITS-1:0] count;
    logic                  last;
  } word_t;

  typedef enum int unsigned {PIX_RANDOM, PIX_FLAT, PIX_GREY, PIX_RAMP} pixel_style_t;

  logic                      clk;
  logic                      rst_n;
  logic                      cfg_wr_en;
  logic [CFG_INDEX_BITS-1:0] cfg_index;
  logic [CFG_DATA_BITS-1:0]  cfg_wdata;
  logic                      in_valid;
  logic                      in_ready;
  logic [PIXEL_BITS-1:0]     in_pixel_rgb565;
  logic                      out_valid;
  logic                      out_ready;
  logic [WORD_BITS-1:0]      out_packed_bits;
  logic [COUNT_BITS-1:0]     out_bit_count;
  logic                      out_last_of_frame;

  // Dither model state
  int unsigned          width_reg;
  int unsigned          height_reg;
  longint               down_line [LINE_COLS][3];
  longint               right_err [3];
  longint               pend_down [2][3];
  int unsigned          col_cnt;
  int unsigned          row_cnt;
  logic [WORD_BITS-1:0] pack_word;
  int unsigned          pack_pos;
  bit                   frame_closed;

  word_t                 expected_words [$];
  bit                    steady_stream;
  logic [PIXEL_BITS-1:0] flat_colour;
  int unsigned           pixels_sent;
  int unsigned           words_checked;
  int unsigned           frames_seen;
  int unsigned           mismatches;

  rgb565_error_diffusion_mono_dither i_dut (
    .clk               (clk),
    .rst_n             (rst_n),
    .cfg_wr_en         (cfg_wr_en),
    .cfg_index         (cfg_index),
    .cfg_wdata         (cfg_wdata),
    .in_valid          (in_valid),
    .in_ready          (in_ready),
    .in_pixel_rgb565   (in_pixel_rgb565),
    .out_valid         (out_valid),
    .out_ready         (out_ready),
    .out_packed_bits   (out_packed_bits),
    .out_bit_count     (out_bit_count),
    .out_last_of_frame (out_last_of_frame)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  // ---------------------------------------------------------------------------
  // Dither model
  // ---------------------------------------------------------------------------
  function automatic longint sat_error(input longint v);
    if (v > ERR_HI) return ERR_HI;
    if (v < ERR_LO) return ERR_LO;
    return v;
  endfunction

  function automatic int unsigned eff_width();
    if (width_reg == 0) return 1;
    if (width_reg > LINE_COLS) return LINE_COLS;
    return width_reg;
  endfunction

  function automatic void reset_dither_state();
    width_reg  = WIDTH_RESET;
    height_reg = HEIGHT_RESET;
    foreach (down_line[i, c]) down_line[i][c] = 0;
    right_err    = '{default: 0};
    pend_down    = '{default: 0};
    col_cnt      = 0;
    row_cnt      = 0;
    pack_word    = '0;
    pack_pos     = 0;
    frame_closed = 1'b1;
  endfunction

  // Advance the model by one pixel and queue any word it completes
  function automatic void dither_pixel(input logic [PIXEL_BITS-1:0] pix);
    longint      chan [3];
    longint      full_lvl [3];
    longint      lum;
    longint      diff;
    longint      head;
    int unsigned w;
    int unsigned h;
    int unsigned x;
    bit          white;
    bit          row_end;
    bit          frame_end;
    w = eff_width();
    h = (height_reg == 0) ? 1 : height_reg;
    x = col_cnt % LINE_COLS;
    full_lvl[0] = FULL_RED;
    full_lvl[1] = FULL_GREEN;
    full_lvl[2] = FULL_BLUE;
    chan[0] = {pix[15:11], 3'b000};
    chan[1] = {pix[10:5], 2'b00};
    chan[2] = {pix[4:0], 3'b000};

    // add error from the row above (none on a frame's first row) and the left
    for (int c = 0; c < 3; c++)
      chan[c] += ((row_cnt == 0) ? 0 : down_line[x][c]) + right_err[c];

    // shift-based luminance, negative channels count as zero
    lum = 0;
    if (chan[0] > 0) lum += (chan[0] * 5) >>> 4;
    if (chan[1] > 0) lum += (chan[1] * 9) >>> 4;
    if (chan[2] > 0) lum += chan[2] >>> 3;
    white   = lum > longint'(LUM_THRESH);
    row_end = (col_cnt + 1 >= w);

    // spread 7/16 right, 3/16 down-left, 5/16 down, 1/16 down-right (floored)
    for (int c = 0; c < 3; c++) begin
      diff = chan[c] - (white ? full_lvl[c] : 0);
      right_err[c] = sat_error((7 * diff) >>> 4);
      if (x > 0) down_line[x - 1][c] = sat_error(pend_down[0][c] + ((3 * diff) >>> 4));
      head = sat_error(pend_down[1][c] + ((5 * diff) >>> 4));
      pend_down[0][c] = head;
      pend_down[1][c] = sat_error(diff >>> 4);
      if (row_end) down_line[x][c] = head;
    end

    if (white) pack_word[pack_pos % WORD_BITS] = 1'b1;
    pack_pos++;

    // advance column and row; drop the row errors at each row end
    frame_end = 1'b0;
    if (row_end) begin
      right_err = '{default: 0};
      pend_down = '{default: 0};
      col_cnt   = 0;
      if (row_cnt + 1 >= h) begin
        frame_end = 1'b1;
        row_cnt   = 0;
      end else begin
        row_cnt++;
      end
    end else begin
      col_cnt++;
    end
    frame_closed = frame_end;

    if (pack_pos >= WORD_BITS || frame_end) begin
      expected_words.push_back(word_t'{pack_word, COUNT_BITS'(pack_pos), frame_end});
      pack_word = '0;
      pack_pos  = 0;
    end
  endfunction

  // ---------------------------------------------------------------------------
  // Stimulus helpers
  // ---------------------------------------------------------------------------
  function automatic int unsigned pick_gap();
    int unsigned roll;
    if (steady_stream) return 0;
    roll = $urandom_range(0, 99);
    if (roll < 60) return 0;
    if (roll < 90) return $urandom_range(1, 3);
    if (roll < 98) return $urandom_range(4, 10);
    return $urandom_range(20, 40);
  endfunction

  function automatic logic [PIXEL_BITS-1:0] make_pixel(input pixel_style_t style);
    int unsigned v;
    case (style)
      PIX_FLAT: return flat_colour;
      PIX_GREY: return {5'(15 + $urandom_range(0, 2)), 6'(31 + $urandom_range(0, 2)),
                        5'(15 + $urandom_range(0, 2))};
      PIX_RAMP: begin
        v = (pixels_sent * 3) % 32;
        return {5'(v), 6'(2 * v), 5'(v)};
      end
      default: return PIXEL_BITS'($urandom);
    endcase
  endfunction

  // Offer one item and hold it until it is taken
  task automatic send_pixel(input logic [PIXEL_BITS-1:0] pix);
    int unsigned gap;
    gap = pick_gap();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid        <= 1'b1;
    in_pixel_rgb565 <= pix;
    do @(posedge clk); while (in_ready !== 1'b1);
    dither_pixel(pix);
    pixels_sent++;
  endtask

  // Send items until the model closes a frame
  task automatic send_frame(input pixel_style_t style);
    frame_closed = 1'b0;
    while (!frame_closed) send_pixel(make_pixel(style));
  endtask

  // Stop sending and let every queued word come out of the pipeline
  task automatic settle();
    in_valid <= 1'b0;
    while (expected_words.size() != 0) @(posedge clk);
    repeat (FLUSH_CYCLES) @(posedge clk);
  endtask

  task automatic program_config(input logic [CFG_DATA_BITS-1:0] width_raw,
                                input logic [CFG_DATA_BITS-1:0] height_raw);
    cfg_wr_en <= 1'b1;
    cfg_index <= CFG_IMAGE_WIDTH;
    cfg_wdata <= width_raw;
    @(posedge clk);
    cfg_index <= CFG_IMAGE_HEIGHT;
    cfg_wdata <= height_raw;
    @(posedge clk);
    cfg_wr_en  <= 1'b0;
    width_reg  = width_raw[WIDTH_BITS-1:0];
    height_reg = height_raw;
  endtask

  // ---------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------
  // Reset geometry: fill one word and leave the first row open
  task automatic test_reset_defaults();
    repeat (40) send_pixel(PIXEL_BITS'($urandom));
    settle();
  endtask

  // Pure colours, extremes and greys either side of the white threshold
  task automatic test_directed_colours();
    logic [PIXEL_BITS-1:0] corner [20] = '{
      16'h0000, 16'hFFFF, 16'hF800, 16'h07E0, 16'h001F, 16'h8410, 16'h8430,
      16'hAAAA, 16'h5555, 16'h0821, 16'hF7DE, 16'h7BEF, 16'hFFE0, 16'h07FF,
      16'hF81F, 16'h8410, 16'h8410, 16'h0000, 16'hFFFF, 16'h1234};
    // narrowing the open default row makes the next item close it
    program_config(16'd4, 16'd3);
    foreach (corner[k]) send_pixel(corner[k]);
    if (!frame_closed) send_frame(PIX_RANDOM);
    settle();
  endtask

  // Width and height of zero, then an over-range width with the row left open
  task automatic test_degenerate_sizes();
    program_config(16'hF800, 16'h0000);
    repeat (6) send_pixel(PIXEL_BITS'($urandom));
    settle();
    program_config(16'hFFFF, 16'd1);
    repeat (48) send_pixel(make_pixel(PIX_RAMP));
    settle();
  endtask

  // Tallest frame, then narrow and cut it short while it is open
  task automatic test_tall_frame();
    program_config(16'd1024, 16'hFFFF);
    repeat (7) send_pixel(PIXEL_BITS'($urandom));
    settle();
    program_config(16'd5, 16'hFFFF);
    repeat (12) send_pixel(PIXEL_BITS'($urandom));
    settle();
    // height below the current row: the frame closes at this row end
    program_config(16'd5, 16'd2);
    send_frame(PIX_GREY);
    settle();
  endtask

  // Random geometries with whole frames, plus frames broken off mid-way
  task automatic test_random_frames();
    int unsigned  start;
    int unsigned  roll;
    int unsigned  w;
    int unsigned  h;
    pixel_style_t style;
    start = pixels_sent;
    while (pixels_sent - start < RANDOM_ITEMS) begin
      // widen only at a frame start, so no unwritten line entry is ever read
      if (col_cnt == 0 && row_cnt == 0) begin
        roll = $urandom_range(0, 99);
        if (roll < 4) w = 0;
        else if (roll < 70) w = $urandom_range(1, 16);
        else if (roll < 95) w = $urandom_range(17, 64);
        else w = $urandom_range(65, 300);
      end else begin
        w = $urandom_range(1, eff_width());
      end
      h = ($urandom_range(0, 9) == 0) ? $urandom_range(7, 20) : $urandom_range(0, 6);
      if (w > 64) h = $urandom_range(0, 2);
      program_config({5'($urandom), 11'(w)}, 16'(h));

      steady_stream = ($urandom_range(0, 3) == 0);
      flat_colour   = PIXEL_BITS'($urandom);
      style         = pixel_style_t'($urandom_range(0, 3));
      if ($urandom_range(0, 5) == 0) begin
        repeat ($urandom_range(1, 40)) send_pixel(make_pixel(style));
      end else begin
        repeat ($urandom_range(1, 3)) send_frame(style);
      end
      steady_stream = 1'b0;
      settle();
    end
  endtask

  // ---------------------------------------------------------------------------
  // Word side: random back-pressure with long runs of ready
  // ---------------------------------------------------------------------------
  initial begin
    int unsigned roll;
    out_ready <= 1'b0;
    @(posedge clk);
    forever begin
      out_ready <= 1'b1;
      repeat ($urandom_range(1, 64)) @(posedge clk);
      roll = $urandom_range(0, 99);
      if (roll >= 40) begin
        out_ready <= 1'b0;
        if (roll < 85) repeat ($urandom_range(1, 3)) @(posedge clk);
        else if (roll < 97) repeat ($urandom_range(4, 12)) @(posedge clk);
        else repeat ($urandom_range(20, 40)) @(posedge clk);
      end
    end
  end

  // Compare each taken word with the oldest prediction
  always @(posedge clk) begin : check_words
    word_t want;
    if (rst_n && out_valid === 1'b1 && out_ready) begin
      if (expected_words.size() == 0) begin
        $display("%0t: unexpected word bits %h count %0d last %0b", $time,
                 out_packed_bits, out_bit_count, out_last_of_frame);
        mismatches++;
      end else begin
        want = expected_words.pop_front();
        if (out_packed_bits !== want.bits) begin
          $display("%0t: packed_bits expected %h actual %h", $time, want.bits,
                   out_packed_bits);
          mismatches++;
        end
        if (out_bit_count !== want.count) begin
          $display("%0t: bit_count expected %0d actual %0d", $time, want.count,
                   out_bit_count);
          mismatches++;
        end
        if (out_last_of_frame !== want.last) begin
          $display("%0t: last_of_frame expected %0b actual %0b", $time, want.last,
                   out_last_of_frame);
          mismatches++;
        end
        words_checked++;
        if (want.last) frames_seen++;
      end
    end
  end

  initial begin : run_tests
    int unsigned waited;
    cfg_wr_en       <= 1'b0;
    cfg_index       <= CFG_IMAGE_WIDTH;
    cfg_wdata       <= '0;
    in_valid        <= 1'b0;
    in_pixel_rgb565 <= '0;
    rst_n           <= 1'b0;
    steady_stream   = 1'b0;
    flat_colour     = '0;
    pixels_sent     = 0;
    words_checked   = 0;
    frames_seen     = 0;
    mismatches      = 0;
    reset_dither_state();
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_reset_defaults();
    test_directed_colours();
    test_degenerate_sizes();
    test_tall_frame();
    test_random_frames();

    // drain, then watch a little longer for stray words
    in_valid <= 1'b0;
    waited = 0;
    while (expected_words.size() != 0 && waited < DRAIN_LIMIT) begin
      @(posedge clk);
      waited++;
    end
    repeat (FLUSH_CYCLES) @(posedge clk);
    if (expected_words.size() != 0) begin
      $display("%0t: %0d predicted words never arrived", $time, expected_words.size());
      mismatches += expected_words.size();
    end

    $display("Dithered %0d pixels into %0d checked words over %0d closed frames,",
             pixels_sent, words_checked, frames_seen);
    $display("including clamped and mid-frame geometry changes; %0d mismatches.",
             mismatches);
    if (mismatches == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

  // Hard stop if the handshakes hang
  initial begin
    #12_000_000;
    $display("%0t: run timed out", $time);
    $display("RESULT: ERROR");
    $finish;
  end

endmodule
